// ===== design/md4_pkg.sv =====
`timescale 1ns / 1ps
package md4_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md4_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_LENGTH,
    ST_OUTPUT
  } md4_state_t;

  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] i;
    begin
      i = step[3:0];
      case (step[5:4])
        2'd0: msg_index = i;
        2'd1: msg_index = {i[1:0], i[3:2]};
        default: msg_index = {i[0], i[1], i[2], i[3]};
      endcase
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [3:0] sel;
    begin
      sel = {step[5:4], step[1:0]};
      case (sel)
        4'd0: rot_amount = 5'd3;
        4'd1: rot_amount = 5'd7;
        4'd2: rot_amount = 5'd11;
        4'd3: rot_amount = 5'd19;
        4'd4: rot_amount = 5'd3;
        4'd5: rot_amount = 5'd5;
        4'd6: rot_amount = 5'd9;
        4'd7: rot_amount = 5'd13;
        4'd8: rot_amount = 5'd3;
        4'd9: rot_amount = 5'd9;
        4'd10: rot_amount = 5'd11;
        4'd11: rot_amount = 5'd15;
        default: rot_amount = 5'd3;
      endcase
    end
  endfunction

endpackage

// ===== design/md4_queue.sv =====
`timescale 1ns / 1ps
module md4_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  md4_pkg::md4_word_t in_word,
  output logic               q_valid,
  input  logic               q_ready,
  output md4_pkg::md4_word_t q_word
);
  import md4_pkg::*;

  md4_word_t slot_r [QUEUE_DEPTH];
  logic      wr_ptr_r;
  logic      rd_ptr_r;
  logic [1:0] count_r;
  logic      push;
  logic      pop;

  assign in_ready = (count_r != 2'(QUEUE_DEPTH));
  assign q_valid  = (count_r != 2'd0);
  assign q_word   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'(QUEUE_DEPTH))
    else $error("queue over capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("count lost a push");

endmodule

// ===== design/md4_core.sv =====
`timescale 1ns / 1ps
module md4_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  md4_pkg::md4_word_t q_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_digest_low,
  output logic [63:0]        out_digest_high
);
  import md4_pkg::*;

  md4_state_t state_r;
  md4_state_t state_nxt;
  logic [31:0] blk_r [16];
  logic [31:0] ch_r [4];
  logic [31:0] v_r [4];
  logic [60:0] count_r;
  logic [5:0]  step_r;
  logic        pend_pad_r;
  logic        pend_len_r;
  logic        pad_done_r;
  logic [63:0] dlow_r;
  logic [63:0] dhigh_r;
  logic        out_valid_r;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [31:0] x, y, z, f, kc, sum, rot, tgt;
  logic [1:0]  t;
  logic [4:0]  sh;
  logic        take;
  logic        last_step;

  assign out_valid       = out_valid_r;
  assign out_digest_low  = dlow_r;
  assign out_digest_high = dhigh_r;
  assign pos  = count_r[5:0];
  assign wsel = pos[5:2];
  assign last_step = (step_r == 6'd47);

  always_comb begin
    t   = 2'd0 - step_r[1:0];
    tgt = v_r[t];
    x   = v_r[t + 2'd1];
    y   = v_r[t + 2'd2];
    z   = v_r[t + 2'd3];
    case (step_r[5:4])
      2'd0: begin
        f  = (x & y) | (~x & z);
        kc = 32'd0;
      end
      2'd1: begin
        f  = (x & y) | (x & z) | (y & z);
        kc = K_ROUND2;
      end
      default: begin
        f  = x ^ y ^ z;
        kc = K_ROUND3;
      end
    endcase
    sum = tgt + f + blk_r[msg_index(step_r)] + kc;
    sh  = rot_amount(step_r);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    take      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        take    = q_valid;
        if (take) begin
          if (q_word.byte_present && pos == 6'd63) begin
            state_nxt = ST_COMPRESS;
          end else if (q_word.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMPRESS: begin
        if (last_step) begin
          if (pend_len_r) begin
            state_nxt = ST_OUTPUT;
          end else if (pend_pad_r) begin
            state_nxt = pad_done_r ? ST_LENGTH : ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        state_nxt = (pos >= 6'd56) ? ST_COMPRESS : ST_LENGTH;
      end
      ST_LENGTH: begin
        state_nxt = ST_COMPRESS;
      end
      ST_OUTPUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && take && q_word.byte_present) begin
      case (pos[1:0])
        2'd0: blk_r[wsel] <= {24'd0, q_word.data_byte};
        2'd1: blk_r[wsel][15:8] <= q_word.data_byte;
        2'd2: blk_r[wsel][23:16] <= q_word.data_byte;
        default: blk_r[wsel][31:24] <= q_word.data_byte;
      endcase
    end
    if (state_r == ST_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > wsel) begin
          blk_r[i] <= 32'd0;
        end
      end
      case (pos[1:0])
        2'd0: blk_r[wsel] <= {24'd0, PAD_BYTE};
        2'd1: blk_r[wsel][15:8] <= PAD_BYTE;
        2'd2: blk_r[wsel][23:16] <= PAD_BYTE;
        default: blk_r[wsel][31:24] <= PAD_BYTE;
      endcase
    end
    if (state_r == ST_COMPRESS && last_step && pend_pad_r && pad_done_r && !pend_len_r) begin
      for (int i = 0; i < 16; i++) begin
        blk_r[i] <= 32'd0;
      end
    end
    if (state_r == ST_LENGTH) begin
      blk_r[14] <= {count_r[28:0], 3'b000};
      blk_r[15] <= count_r[60:29];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        ch_r[i] <= (i == 0) ? INIT_A : (i == 1) ? INIT_B : (i == 2) ? INIT_C : INIT_D;
      end
      count_r     <= 61'd0;
      step_r      <= 6'd0;
      pend_pad_r  <= 1'b0;
      pend_len_r  <= 1'b0;
      pad_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_OUTPUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (q_word.byte_present) begin
              count_r <= count_r + 61'd1;
            end
            pend_pad_r <= q_word.end_of_message;
            pend_len_r <= 1'b0;
            pad_done_r <= 1'b0;
            step_r     <= 6'd0;
            for (int i = 0; i < 4; i++) begin
              v_r[i] <= ch_r[i];
            end
          end
        end
        ST_COMPRESS: begin
          if (last_step) begin
            step_r <= 6'd0;
            for (int i = 0; i < 4; i++) begin
              ch_r[i] <= ch_r[i] + ((2'(i) == t) ? rot : v_r[i]);
              v_r[i]  <= ch_r[i] + ((2'(i) == t) ? rot : v_r[i]);
            end
          end else begin
            v_r[t] <= rot;
            step_r <= step_r + 6'd1;
          end
        end
        ST_PAD: begin
          pad_done_r <= 1'b1;
        end
        ST_LENGTH: begin
          pend_len_r <= 1'b1;
        end
        ST_OUTPUT: begin
          if (!out_valid_r || out_ready) begin
            dlow_r      <= {ch_r[1], ch_r[0]};
            dhigh_r     <= {ch_r[3], ch_r[2]};
            out_valid_r <= 1'b1;
            ch_r[0]     <= INIT_A;
            ch_r[1]     <= INIT_B;
            ch_r[2]     <= INIT_C;
            ch_r[3]     <= INIT_D;
            count_r     <= 61'd0;
            pend_pad_r  <= 1'b0;
            pend_len_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COMPRESS) |-> (step_r == 6'd0))
    else $error("step counter runs outside compression");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUTPUT) |-> pend_len_r)
    else $error("digest without length block");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(dlow_r)))
    else $error("held digest changed");

endmodule

// ===== design/md4_message_digest.sv =====
`timescale 1ns / 1ps
// Byte-serial MD4 hash. Each input word carries in_data_byte, in_byte_present and
// in_end_of_message on a valid/ready channel. A two-entry queue takes words while
// the core is compressing. The core takes bytes while idle; the 64th byte of a
// block starts a compression, one round step per cycle.
// A word with in_end_of_message set pads the block, appends the bit length and
// runs one or two compressions, after which the digest appears on out_digest_low
// and out_digest_high with out_valid.
// The digest is held in an output register until out_ready takes it; a stalled
// receiver blocks only the next digest, and the core keeps hashing bytes of the
// following message until that point.
// Synchronous active-low reset empties the queue, drops any pending digest and
// restores the initial chaining values with a zero byte count.
module md4_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);
  import md4_pkg::*;

  md4_word_t in_word;
  md4_word_t q_word;
  logic      q_valid;
  logic      q_ready;

  assign in_word = '{data_byte: in_data_byte, byte_present: in_byte_present,
                     end_of_message: in_end_of_message};

  md4_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word)
  );

  md4_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_word          (q_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_low  (out_digest_low),
    .out_digest_high (out_digest_high)
  );

endmodule

// ===== verif/md4_checker.sv =====
`timescale 1ns / 1ps
module md4_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_low,
  input  logic [63:0] out_digest_high,
  output int          fail_count,
  output int          outstanding
);
  import md4_pkg::*;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  localparam int WORD_ORDER [48] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
    0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
  };
  localparam int SHIFTS [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

  logic [31:0] msg_words [16];
  logic [31:0] chain [4];
  logic [60:0] msg_length;
  digest_t     digest_queue [$];

  assign outstanding = digest_queue.size();

  function automatic void restart_chain();
    chain[0] = INIT_A;
    chain[1] = INIT_B;
    chain[2] = INIT_C;
    chain[3] = INIT_D;
    msg_length = '0;
  endfunction

  function automatic void place_byte(int pos, logic [7:0] b);
    int w;
    int sh;
    w = (pos >> 2) & 15;
    sh = (pos & 3) * 8;
    if (sh == 0) begin
      msg_words[w] = {24'd0, b};
    end else begin
      msg_words[w][sh +: 8] = b;
    end
  endfunction

  function automatic void hash_block();
    logic [31:0] v [4];
    logic [31:0] x, y, z, f, k, sum;
    int t;
    int s;
    for (int j = 0; j < 4; j++) v[j] = chain[j];
    for (int i = 0; i < 48; i++) begin
      t = (4 - (i & 3)) & 3;
      x = v[(t + 1) & 3];
      y = v[(t + 2) & 3];
      z = v[(t + 3) & 3];
      if (i < 16) begin
        f = (x & y) | (~x & z);
        k = '0;
      end else if (i < 32) begin
        f = (x & y) | (x & z) | (y & z);
        k = K_ROUND2;
      end else begin
        f = x ^ y ^ z;
        k = K_ROUND3;
      end
      sum = v[t] + f + msg_words[WORD_ORDER[i]] + k;
      s = SHIFTS[((i >> 4) << 2) + (i & 3)];
      v[t] = (sum << s) | (sum >> (32 - s));
    end
    for (int j = 0; j < 4; j++) chain[j] = chain[j] + v[j];
  endfunction

  function automatic void absorb_word(logic [7:0] b, logic present, logic last);
    int pos;
    logic [63:0] bits;
    digest_t d;
    if (present) begin
      pos = int'(msg_length[5:0]);
      place_byte(pos, b);
      msg_length = msg_length + 1'b1;
      if (pos == 63) hash_block();
    end
    if (last) begin
      pos = int'(msg_length[5:0]);
      place_byte(pos, PAD_BYTE);
      for (int w = (pos >> 2) + 1; w < 16; w++) msg_words[w] = '0;
      if (pos >= 56) begin
        hash_block();
        for (int w = 0; w < 16; w++) msg_words[w] = '0;
      end
      bits = {msg_length, 3'b000};
      msg_words[14] = bits[31:0];
      msg_words[15] = bits[63:32];
      hash_block();
      d.low = {chain[1], chain[0]};
      d.high = {chain[3], chain[2]};
      digest_queue.push_back(d);
      restart_chain();
    end
  endfunction

  always @(posedge clk) begin
    digest_t want;
    if (!rst_n) begin
      for (int w = 0; w < 16; w++) msg_words[w] = '0;
      restart_chain();
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Unexpected digest %h %h", out_digest_high, out_digest_low);
        end else begin
          want = digest_queue.pop_front();
          if (out_digest_low !== want.low) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest_low: expected %h, got %h", want.low, out_digest_low);
          end
          if (out_digest_high !== want.high) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest_high: expected %h, got %h", want.high, out_digest_high);
          end
        end
      end
      if (in_valid && in_ready)
        absorb_word(in_data_byte, in_byte_present, in_end_of_message);
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 850;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;
  int          fail_count;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          hold_request;
  int          hold_left;
  int          words_sent;
  int          cycle_count;

  md4_message_digest DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_byte_present(in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_low(out_digest_low), .out_digest_high(out_digest_high)
  );

  md4_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_byte_present(in_byte_present),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_low(out_digest_low), .out_digest_high(out_digest_high),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver takes a long break when asked, otherwise it stalls at random.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic [7:0] b, logic present, logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_message(int length);
    logic carry_last;
    carry_last = (length > 0) && $urandom_range(1);
    for (int i = 0; i < length; i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, carry_last && (i == length - 1));
    end
    if (!carry_last) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_length();
    case ($urandom_range(5))
      0: pick_length = $urandom_range(3);
      1: pick_length = $urandom_range(54, 57);
      2: pick_length = $urandom_range(62, 65);
      3: pick_length = $urandom_range(118, 129);
      default: pick_length = $urandom_range(30);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_present = 1'b0;
    in_end_of_message = 1'b0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    words_sent = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (phase == 0) begin
        hold_request = 600;
        for (int m = 0; m < 8; m++) send_message($urandom_range(3));
        drain();
      end
      while (words_sent < WORD_TARGET * (phase + 1) / 4) begin
        if ($urandom_range(9) == 0) begin
          send_word(8'($urandom), 1'b0, 1'b0);
        end else begin
          send_message(pick_length());
        end
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
